[sv/i8dq_pkg.sv]
// Package for the int8 to fp32 dequantiser: constants, stage types.
// Used by every module of the block; no dependencies.
package i8dq_pkg;

    localparam logic [31:0] SCALE_RESET  = 32'h3F80_0000;
    localparam logic [31:0] DEFAULT_NAN  = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
    localparam logic [31:0] INF_BITS     = 32'h7F80_0000;

    // result kinds decided in the first stage
    localparam logic [1:0] KIND_NORM  = 2'd0;
    localparam logic [1:0] KIND_FIXED = 2'd1;

    typedef struct packed {
        logic        last;
        logic [1:0]  kind;
        logic [31:0] fixed;   // result when not a finite nonzero product
        logic        sign;
        logic [8:0]  ebias;   // effective biased exponent of the scale (1..255)
        logic [31:0] prod;    // magnitude times significand, fits 31 bits
    } mul_stage_t;

    typedef struct packed {
        logic        last;
        logic [1:0]  kind;
        logic [31:0] fixed;
        logic        sign;
        logic [8:0]  ebias;
        logic [31:0] prod;
        logic [4:0]  msb;     // index of leading one of prod
    } lz_stage_t;

endpackage

[sv/i8dq_if.sv]
// Valid/ready stream interfaces for the dequantiser.
// Depends on nothing.
interface i8dq_in_if;
    logic             valid;
    logic             ready;
    logic signed [7:0] quant_value;
    logic             last_elem;
    modport source (output valid, output quant_value, output last_elem, input ready);
    modport sink   (input valid, input quant_value, input last_elem, output ready);
endinterface

interface i8dq_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] fp32_bits;
    logic        last_out;
    modport source (output valid, output fp32_bits, output last_out, input ready);
    modport sink   (input valid, input fp32_bits, input last_out, output ready);
endinterface

interface i8dq_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] scale_bits;
    modport source (output valid, output scale_bits, input ready);
    modport sink   (input valid, input scale_bits, output ready);
endinterface

[sv/i8dq_mul.sv]
// Stage 1: decode operands, classify special cases, form the integer product.
// Depends on i8dq_pkg.
module i8dq_mul
    import i8dq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic signed [7:0] quant_value,
    input  logic              last_elem,
    input  logic [31:0]       scale,
    output logic              valid_reg,
    output mul_stage_t        data_reg
);
    logic       sa;
    logic [7:0] mag;
    logic [7:0] eb;
    logic [22:0] fb;
    logic       sg;
    mul_stage_t data_next;

    always_comb
    begin
        sa  = quant_value[7];
        mag = sa ? (8'd0 - quant_value) : quant_value;
        eb  = scale[30:23];
        fb  = scale[22:0];
        sg  = sa ^ scale[31];
        data_next.last  = last_elem;
        data_next.sign  = sg;
        data_next.kind  = KIND_NORM;
        data_next.fixed = {sg, 31'd0};
        data_next.ebias = (eb == 8'd0) ? 9'd1 : {1'b0, eb};
        data_next.prod  = {16'd0, mag} * {8'd0, (eb != 8'd0), fb};
        if (eb == 8'hFF && fb != 23'd0)
        begin
            data_next.kind  = KIND_FIXED;
            data_next.fixed = scale | QUIET_BIT;
        end
        else if (eb == 8'hFF)
        begin
            data_next.kind  = KIND_FIXED;
            data_next.fixed = (mag == 8'd0) ? DEFAULT_NAN : ({sg, 31'd0} | INF_BITS);
        end
        else if (mag == 8'd0 || (eb == 8'd0 && fb == 23'd0))
        begin
            data_next.kind = KIND_FIXED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end
endmodule

[sv/i8dq_lz.sv]
// Stage 2: find the leading one of the product.
// Depends on i8dq_pkg.
module i8dq_lz
    import i8dq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  mul_stage_t in_data,
    output logic       valid_reg,
    output lz_stage_t  data_reg
);
    lz_stage_t data_next;

    always_comb
    begin
        data_next.last  = in_data.last;
        data_next.kind  = in_data.kind;
        data_next.fixed = in_data.fixed;
        data_next.sign  = in_data.sign;
        data_next.ebias = in_data.ebias;
        data_next.prod  = in_data.prod;
        data_next.msb   = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (in_data.prod[i])
                data_next.msb = 5'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end
endmodule

[sv/i8dq_rnd.sv]
// Stage 3: align, round to nearest even, pack; holds the output register.
// Depends on i8dq_pkg.
module i8dq_rnd
    import i8dq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  lz_stage_t  in_data,
    output logic       valid_reg,
    output logic [31:0] bits_reg,
    output logic       last_reg
);
    // value = prod * 2^(ebias-150); signed exponent arithmetic in 11 bits
    logic signed [10:0] shift;
    logic signed [10:0] min_shift;
    logic [5:0]         rsh;
    logic [5:0]         lsh;
    logic [31:0]        q;
    logic [31:0]        rem_mask;
    logic [31:0]        half;
    logic [31:0]        rem;
    logic [31:0]        qr;
    logic signed [10:0] biased;
    logic [31:0]        bits_next;

    always_comb
    begin
        shift     = $signed({6'd0, in_data.msb}) - 11'sd23;
        min_shift = 11'sd1 - $signed({2'd0, in_data.ebias});
        if (shift < min_shift)
            shift = min_shift;
        rsh = 6'd0;
        lsh = 6'd0;
        if (shift > 0)
            rsh = shift[5:0];
        else
            lsh = 6'(-shift);
        rem_mask = (32'd1 << rsh) - 32'd1;
        half     = (rsh == 6'd0) ? 32'd0 : (32'd1 << (rsh - 6'd1));
        rem      = in_data.prod & rem_mask;
        if (shift > 0)
            q = in_data.prod >> rsh;
        else
            q = in_data.prod << lsh;
        qr = q;
        if (shift > 0 && (rem > half || (rem == half && q[0])))
            qr = q + 32'd1;
        biased = $signed({2'd0, in_data.ebias}) + shift;
        if (qr[24])
        begin
            qr     = qr >> 1;
            biased = biased + 11'sd1;
        end
        if (in_data.kind == KIND_FIXED)
            bits_next = in_data.fixed;
        else if (qr[23])
        begin
            if (biased >= 11'sd255)
                bits_next = {in_data.sign, 31'd0} | INF_BITS;
            else
                bits_next = {in_data.sign, biased[7:0], qr[22:0]};
        end
        else
            bits_next = {in_data.sign, 8'd0, qr[22:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bits_reg <= bits_next;
            last_reg <= in_data.last;
        end
    end
endmodule

[sv/int8_dequant_to_fp32.sv]
// Top level of the int8 to fp32 dequantiser.
// Depends on i8dq_pkg, the stream interfaces and the three stage modules.
//
// Takes one int8 item per cycle unless the output item is held, and returns
// value times the fp32 scale, IEEE round-to-nearest-even; the last
// marker travels with it. The three register stages (product, leading-one
// search, round and pack) advance together whenever the output register is
// empty or being taken, so a full pipeline sustains one item per cycle.
// Write the scale only while no item is in flight.
module int8_dequant_to_fp32
    import i8dq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    i8dq_in_if.sink    in_ch,
    i8dq_out_if.source out_ch,
    i8dq_cfg_if.sink   cfg
);
    logic [31:0] scale_val_reg;
    logic       en;
    logic       v1, v2, v3;
    mul_stage_t d1;
    lz_stage_t  d2;
    logic [31:0] bits3;
    logic       last3;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_val_reg <= SCALE_RESET;
        else if (cfg.valid)
            scale_val_reg <= cfg.scale_bits;
    end

    // advance everything unless the output item is held
    assign en          = !v3 || out_ch.ready;
    assign in_ch.ready = en;

    i8dq_mul u_mul (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_ch.valid),
        .quant_value(in_ch.quant_value), .last_elem(in_ch.last_elem),
        .scale(scale_val_reg), .valid_reg(v1), .data_reg(d1)
    );

    i8dq_lz u_lz (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v1), .in_data(d1),
        .valid_reg(v2), .data_reg(d2)
    );

    i8dq_rnd u_rnd (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2), .in_data(d2),
        .valid_reg(v3), .bits_reg(bits3), .last_reg(last3)
    );

    assign out_ch.valid     = v3;
    assign out_ch.fp32_bits = bits3;
    assign out_ch.last_out  = last3;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3 && !out_ch.ready |=> v3 && $stable(bits3) && $stable(last3))
        else $error("output item changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready == (!v3 || out_ch.ready))
        else $error("input ready does not follow pipeline enable");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        en && v2 |=> v3)
        else $error("item lost between stages");
endmodule

[tb/tb_if.sv]
// Testbench-side note: the stream and configuration interfaces come from the RTL
// file sv/i8dq_if.sv; this file holds the shared pacing helpers for the bench.
// Depends on nothing.
package tb_pace_pkg;

    // Often no gap, about as often a short one, now and then a long one; no gap when busy.
    function automatic int unsigned gap_len(input bit busy_phase);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (busy_phase)
            return 0;
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

endpackage

[tb/testbench.sv]
// Regression bench for int8_dequant_to_fp32: streams int8 items at random pace,
// predicts value times scale bit for bit and checks every result in order.
// Depends on i8dq_pkg, the RTL stream interfaces and tb_pace_pkg.
module testbench
    import i8dq_pkg::*, tb_pace_pkg::*;
;

    typedef struct packed {
        logic [31:0] bits;
        logic        last;
    } dequant_res_t;

    logic clk;
    logic rst_n;

    i8dq_in_if  in_ch ();
    i8dq_out_if out_ch ();
    i8dq_cfg_if cfg ();

    int8_dequant_to_fp32 dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    dequant_res_t expected_q[$];
    logic [31:0]  scale_reg;
    int unsigned  mismatches;
    int unsigned  results_seen;
    bit           sink_busy;

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // Product of an int8 value and an fp32 pattern, round to nearest even.
    function automatic logic [31:0] dequant(input logic signed [7:0] qv, input logic [31:0] s);
        logic        sgn;
        logic [7:0]  mag;
        logic [7:0]  eb;
        logic [22:0] fb;
        logic [63:0] p, q, rem, half;
        int          e, ex, k, sh, u, biased;
        mag = qv[7] ? 8'(-qv) : qv[7:0];
        eb  = s[30:23];
        fb  = s[22:0];
        sgn = qv[7] ^ s[31];
        if (eb == 8'hFF && fb != 0)
            return s | QUIET_BIT;
        if (eb == 8'hFF)
            return (mag == 0) ? DEFAULT_NAN : {sgn, INF_BITS[30:0]};
        if (mag == 0 || (eb == 0 && fb == 0))
            return {sgn, 31'd0};
        if (eb == 0)
        begin
            p = 64'(mag) * 64'(fb);
            e = 1;
        end
        else
        begin
            p = 64'(mag) * 64'({1'b1, fb});
            e = eb;
        end
        ex = e - 150;
        k = 0;
        while (k < 63 && (p >> (k + 1)) != 0)
            k++;
        sh = k - 23;
        if (sh < -149 - ex)
            sh = -149 - ex;
        if (sh <= 0)
            q = p << (-sh);
        else
        begin
            q    = p >> sh;
            rem  = p & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0]))
                q++;
        end
        u = ex + sh;
        if (q >= (64'd1 << 24))
        begin
            q = q >> 1;
            u++;
        end
        if (q >= (64'd1 << 23))
        begin
            biased = u + 150;
            if (biased >= 255)
                return {sgn, INF_BITS[30:0]};
            return {sgn, 8'(biased), q[22:0]};
        end
        return {sgn, q[30:0]};
    endfunction

    // Entered at a falling edge; leaves valid high so a following item can go straight on.
    task automatic send_item(input logic signed [7:0] qv, input logic lst, input bit busy);
        int unsigned g;
        g = gap_len(busy);
        if (g != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.quant_value <= qv;
        in_ch.last_elem   <= lst;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_q.push_back('{dequant(qv, scale_reg), lst});
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Idle the pipe, then load a new scale.
    task automatic write_scale(input logic [31:0] s);
        drain();
        @(negedge clk);
        cfg.valid      <= 1'b1;
        cfg.scale_bits <= s;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        scale_reg = s;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic sweep_all_values(input bit busy);
        for (int v = -128; v <= 127; v++)
            send_item(8'(v), v == 127, busy);
    endtask

    task automatic test_reset_scale();
        send_item(8'sd127, 1'b0, 1'b1);
        send_item(-8'sd128, 1'b0, 1'b1);
        send_item(8'sd0, 1'b1, 1'b0);
        send_item(8'sd1, 1'b0, 1'b0);
        send_item(-8'sd1, 1'b1, 1'b0);
    endtask

    task automatic test_special_scales();
        logic [31:0] specials[12];
        logic signed [7:0] vals[5];
        specials = '{32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
                     32'hFFA5_5555, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001,
                     32'h807F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0080_0000};
        vals = '{8'sd0, 8'sd1, -8'sd1, 8'sd127, -8'sd128};
        foreach (specials[i])
        begin
            write_scale(specials[i]);
            foreach (vals[j])
                send_item(vals[j], j == 4, 1'b0);
        end
    endtask

    // Scales near the overflow and underflow edges, infinities and NaNs, mid-range and random patterns.
    task automatic test_random(input int n_phases, input int per_phase);
        logic [31:0] s;
        int unsigned pick;
        for (int ph = 0; ph < n_phases; ph++)
        begin
            pick = $urandom_range(0, 5);
            s = $urandom();
            case (pick)
                0: s[30:23] = 8'($urandom_range(240, 254));
                1: s[30:23] = 8'($urandom_range(0, 8));
                2: s[30:23] = 8'hFF;
                3: s[30:23] = 8'($urandom_range(100, 150));
                default: ;
            endcase
            write_scale(s);
            for (int i = 0; i < per_phase; i++)
                send_item(8'($urandom()), 1'($urandom()), (ph % 4) == 1);
            if (ph == 3)
                drain();
        end
    endtask

    // Check results in acceptance order.
    always @(posedge clk)
    begin
        dequant_res_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h last %b", out_ch.fp32_bits, out_ch.last_out);
            end
            else
            begin
                want = expected_q.pop_front();
                if (want.bits !== out_ch.fp32_bits || want.last !== out_ch.last_out)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want %h/%b got %h/%b", want.bits, want.last,
                                 out_ch.fp32_bits, out_ch.last_out);
                end
            end
        end
    end

    // Sink stalls at random, with busy stretches of no stalling.
    always @(negedge clk)
    begin
        int unsigned g;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            g = gap_len(sink_busy);
            out_ch.ready <= (g == 0);
            if ($urandom_range(0, 63) == 0)
                sink_busy <= ~sink_busy;
        end
    end

    initial
    begin
        #400000;
        $display("int8_dequant_to_fp32 regression: fail");
        $finish;
    end

    initial
    begin
        mismatches        = 0;
        results_seen      = 0;
        scale_reg         = SCALE_RESET;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.quant_value = '0;
        in_ch.last_elem   = 1'b0;
        cfg.valid         = 1'b0;
        cfg.scale_bits    = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_scale();
        test_special_scales();
        write_scale(32'h3E00_0001);
        sweep_all_values(1'b1);
        test_random(15, 50);
        write_scale(32'hFFFF_FFFF);
        sweep_all_values(1'b0);
        write_scale(32'h0000_0000);
        send_item(-8'sd5, 1'b1, 1'b0);
        drain();

        if (mismatches == 0 && expected_q.size() == 0)
            $display("int8_dequant_to_fp32 regression: pass");
        else
            $display("int8_dequant_to_fp32 regression: fail");
        $finish;
    end

endmodule
